// File: hw/rtl/rldd_pkg.sv
// shared constants, command and status types for the lock manager
package rldd_pkg;

    localparam int PROCESSES = 16;
    localparam int RESOURCES = 16;
    localparam int PROC_W    = $clog2(PROCESSES);
    localparam int RES_W     = $clog2(RESOURCES);

    typedef struct packed {
        logic load;      // capture the input beat
        logic update;    // apply holder and wait table changes
        logic init;      // first reachability step from the root
        logic grow;      // one more reachability round
        logic publish;   // move the result into the output register
    } rldd_cmd_t;

    typedef struct packed {
        logic searched;  // the request calls for a deadlock check
        logic stable;    // next round adds no process
        logic hit;       // root already reached
        logic out_free;  // output register can take a result
    } rldd_status_t;

endpackage

// File: hw/rtl/rldd_ctrl.sv
// controller state machine for request update and cycle search
module rldd_ctrl
    import rldd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  rldd_status_t status,
    output rldd_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_INIT,
        ST_GROW,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_INIT;
            end
            ST_INIT: begin
                if (status.searched) begin
                    cmd.init   = 1'b1;
                    state_next = ST_GROW;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_GROW: begin
                if (status.hit || status.stable) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.grow = 1'b1;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/rldd_dp.sv
// datapath: holder table, wait matrix, reachability set and output register
module rldd_dp
    import rldd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  rldd_cmd_t         cmd,
    output rldd_status_t      status,
    input  logic              s_req_type,
    input  logic [PROC_W-1:0] s_process,
    input  logic [RES_W-1:0]  s_resource,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_granted,
    output logic [PROC_W-1:0] m_new_holder,
    output logic              m_searched,
    output logic [PROC_W-1:0] m_search_root,
    output logic              m_deadlock
);

    // captured request
    logic              kind_reg;
    logic [PROC_W-1:0] proc_reg;
    logic [RES_W-1:0]  res_reg;

    // tables
    logic                 hold_vld_reg [RESOURCES];
    logic [PROC_W-1:0]    hold_id_reg  [RESOURCES];
    logic [RESOURCES-1:0] wait_reg     [PROCESSES];

    // request outcome
    logic              granted_reg;
    logic [PROC_W-1:0] holder_reg;
    logic              searched_reg;
    logic [PROC_W-1:0] root_reg;

    logic [PROCESSES-1:0] reach_reg;
    logic                 m_valid_reg;

    // update decode
    logic              res_held;
    logic              waiter_found;
    logic [PROC_W-1:0] waiter;
    logic              granted_next;
    logic [PROC_W-1:0] holder_next;
    logic              searched_next;
    logic [PROC_W-1:0] root_next;

    always_comb begin
        res_held     = hold_vld_reg[res_reg];
        waiter_found = 1'b0;
        waiter       = '0;
        for (int i = PROCESSES - 1; i >= 0; i--) begin
            if (wait_reg[i][res_reg]) begin
                waiter_found = 1'b1;
                waiter       = PROC_W'(i);
            end
        end
        granted_next  = 1'b0;
        holder_next   = '0;
        searched_next = 1'b0;
        root_next     = '0;
        if (!kind_reg) begin
            granted_next  = !res_held;
            holder_next   = res_held ? '0 : proc_reg;
            searched_next = 1'b1;
            root_next     = proc_reg;
        end else if (res_held && waiter_found) begin
            granted_next  = 1'b1;
            holder_next   = waiter;
            searched_next = 1'b1;
            root_next     = waiter;
        end
    end

    // one reachability step: waited resources of the set, then their holders
    logic [PROCESSES-1:0] step_src;
    logic [RESOURCES-1:0] step_res;
    logic [PROCESSES-1:0] step_dst;
    logic [PROCESSES-1:0] grown;

    always_comb begin
        // empty set steps from the root, so an empty first step stays empty
        step_src = (reach_reg == '0) ? (PROCESSES'(1) << root_reg) : reach_reg;
        step_res = '0;
        for (int p = 0; p < PROCESSES; p++) begin
            if (step_src[p]) begin
                step_res = step_res | wait_reg[p];
            end
        end
        step_dst = '0;
        for (int r = 0; r < RESOURCES; r++) begin
            if (step_res[r] && hold_vld_reg[r]) begin
                step_dst[hold_id_reg[r]] = 1'b1;
            end
        end
        grown = reach_reg | step_dst;
    end

    always_comb begin
        status.searched = searched_reg;
        status.stable   = (grown == reach_reg);
        status.hit      = reach_reg[root_reg];
        status.out_free = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= s_req_type;
            proc_reg <= s_process;
            res_reg  <= s_resource;
        end
        if (cmd.update) begin
            granted_reg  <= granted_next;
            holder_reg   <= holder_next;
            searched_reg <= searched_next;
            root_reg     <= root_next;
            reach_reg    <= '0;
        end else if (cmd.init) begin
            reach_reg <= step_dst;
        end else if (cmd.grow) begin
            reach_reg <= grown;
        end
    end

    // table state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < RESOURCES; r++) begin
                hold_vld_reg[r] <= 1'b0;
            end
            for (int p = 0; p < PROCESSES; p++) begin
                wait_reg[p] <= '0;
            end
        end else if (cmd.update) begin
            if (!kind_reg) begin
                if (res_held) begin
                    wait_reg[proc_reg][res_reg] <= 1'b1;
                end else begin
                    hold_vld_reg[res_reg] <= 1'b1;
                    hold_id_reg[res_reg]  <= proc_reg;
                end
            end else if (res_held) begin
                if (waiter_found) begin
                    wait_reg[waiter][res_reg] <= 1'b0;
                    hold_id_reg[res_reg]      <= waiter;
                end else begin
                    hold_vld_reg[res_reg] <= 1'b0;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            m_granted     <= granted_reg;
            m_new_holder  <= holder_reg;
            m_searched    <= searched_reg;
            m_search_root <= root_reg;
            m_deadlock    <= searched_reg && reach_reg[root_reg];
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: hw/rtl/resource_lock_deadlock_detector.sv
// top level of the lock manager with deadlock check
//
//  channel | ports                                             | direction
//  --------+---------------------------------------------------+----------
//  request | s_valid s_ready s_req_type s_process s_resource   | in
//  result  | m_valid m_ready m_granted m_new_holder m_searched | out
//          | m_search_root m_deadlock                          |
//
// one beat at a time: capture, table update, then the reachability search
// one beat runs through idle, update and search init, then the search rounds when the request
// calls for a check, and finish; the rounds run in the set-expansion step, one per cycle
// reset clears the holder valid bits and the wait matrix
// a result waiting in the output register stalls only the finish step
module resource_lock_deadlock_detector
    import rldd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    input  logic [PROC_W-1:0] s_process,
    input  logic [RES_W-1:0]  s_resource,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_granted,
    output logic [PROC_W-1:0] m_new_holder,
    output logic              m_searched,
    output logic [PROC_W-1:0] m_search_root,
    output logic              m_deadlock
);

    // commands from controller, status back from datapath
    rldd_cmd_t    cmd;
    rldd_status_t status;

    // sequencing: idle, update, search init, search rounds, publish
    rldd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // tables, reachability set and the result register
    rldd_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_req_type    (s_req_type),
        .s_process     (s_process),
        .s_resource    (s_resource),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_granted     (m_granted),
        .m_new_holder  (m_new_holder),
        .m_searched    (m_searched),
        .m_search_root (m_search_root),
        .m_deadlock    (m_deadlock)
    );

endmodule

// File: hw/rtl/rldd_checker.sv
// port-level assertions for the lock manager and their bind
module rldd_checker
    import rldd_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_granted,
    input logic [PROC_W-1:0] m_new_holder,
    input logic              m_searched,
    input logic [PROC_W-1:0] m_search_root,
    input logic              m_deadlock
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_holder)
            && $stable(m_search_root) && $stable(m_deadlock))
        else $error("result beat changed while stalled");

    // a grant always runs a check rooted at the new holder
    a_grant_root: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_granted |-> m_searched && (m_search_root == m_new_holder))
        else $error("grant without matching search root");

    // no check means all search fields zero and no grant
    a_no_search: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_searched |-> !m_deadlock && (m_search_root == '0)
            && !m_granted)
        else $error("search fields set without a check");

    // one request in flight: ready drops after an accept
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

endmodule

bind resource_lock_deadlock_detector rldd_checker u_rldd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_granted     (m_granted),
    .m_new_holder  (m_new_holder),
    .m_searched    (m_searched),
    .m_search_root (m_search_root),
    .m_deadlock    (m_deadlock)
);
